// ===== sv/omp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// omp_pkg
// Shared types and constants for the orthographic map point projector:
// pen action codes, register indexes, chord threshold ratio, screen limits.
// ----------------------------------------------------------------------------
package omp_pkg;

   // Pen action carried with every result item
   typedef enum logic [1:0] {
      PEN_MOVE  = 2'd0,
      PEN_LINE  = 2'd1,
      PEN_COLOR = 2'd2
   } pen_action_type;

   // Register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_SIN_CENTER_LAT = 3'd0,
      CSR_COS_CENTER_LAT = 3'd1,
      CSR_SIN_CENTER_LNG = 3'd2,
      CSR_COS_CENTER_LNG = 3'd3,
      CSR_PIXEL_SCALE    = 3'd4,
      CSR_HALF_WIDTH     = 3'd5,
      CSR_HALF_HEIGHT    = 3'd6
   } csr_index_type;

   // Squared chord limit is 1.9 = CHORD_NUM / CHORD_DEN
   localparam int CHORD_NUM = 19;
   localparam int CHORD_DEN = 10;

   // Screen coordinate saturation limits
   localparam int SCREEN_MAX = 32767;
   localparam int SCREEN_MIN = -32768;

endpackage
`default_nettype wire

// ===== sv/omp_chord.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// omp_chord
// Four-stage check of the squared chord distance between the rotated vertex
// and the view center: near is high when 0 < dx^2+dy^2+dz^2 <= 1.9.
// ----------------------------------------------------------------------------
module omp_chord #(
   parameter int F    = 14,
   parameter int W_XC = 35
) (
   input  wire                      clock,
   input  wire logic signed [W_XC-1:0] xc,
   input  wire logic signed [W_XC-1:0] zc,
   input  wire logic signed [15:0]  sin_lat,
   input  wire logic signed [15:0]  sin_center_lat,
   input  wire logic signed [15:0]  cos_center_lat,
   output logic                     near
);

   localparam int W_DZR = ((W_XC > 16 + F) ? W_XC : 16 + F) + 1;
   localparam int W_D1  = (W_DZR > 2 * F + 3) ? W_DZR : 2 * F + 3;
   localparam int W_D   = W_D1 - F;
   localparam int W_M   = F + 1;
   localparam int W_SQ  = 2 * F + 4;
   localparam logic [63:0] ONE_2F = 64'd1 << (2 * F);
   localparam logic [63:0] THR =
      (ONE_2F / omp_pkg::CHORD_DEN) * omp_pkg::CHORD_NUM +
      ((ONE_2F % omp_pkg::CHORD_DEN) * omp_pkg::CHORD_NUM) / omp_pkg::CHORD_DEN;
   localparam logic [W_SQ-1:0] THR_Q = THR[W_SQ-1:0];

   // stage c1: deltas at F fraction bits, truncated toward zero
   logic signed [W_D-1:0] dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;

   always_comb begin
      logic signed [W_D1-1:0] xe, xa, zr, za;
      logic signed [16:0]     dy;
      xe = W_D1'(xc);
      xa = xe + W_D1'({F{xe[W_D1-1]}});
      zr = W_D1'(zc) - W_D1'($signed({cos_center_lat, {F{1'b0}}}));
      za = zr + W_D1'({F{zr[W_D1-1]}});
      dy = 17'(sin_lat) - 17'(sin_center_lat);
      dx_in = $signed(xa[W_D1-1:F]);
      dz_in = $signed(za[W_D1-1:F]);
      dy_in = W_D'(dy);
   end

   // stage c2: magnitudes, out-of-reach and nonzero flags
   logic [W_M-1:0] mx_ff, my_ff, mz_ff, mx_in, my_in, mz_in;
   logic           big2_ff, nz2_ff, big2_in, nz2_in;

   always_comb begin
      logic [W_D-1:0] ax, ay, az;
      ax = dx_ff[W_D-1] ? W_D'(-dx_ff) : W_D'(dx_ff);
      ay = dy_ff[W_D-1] ? W_D'(-dy_ff) : W_D'(dy_ff);
      az = dz_ff[W_D-1] ? W_D'(-dz_ff) : W_D'(dz_ff);
      mx_in   = ax[W_M-1:0];
      my_in   = ay[W_M-1:0];
      mz_in   = az[W_M-1:0];
      big2_in = (|ax[W_D-1:W_M]) | (|ay[W_D-1:W_M]) | (|az[W_D-1:W_M]);
      nz2_in  = (dx_ff != '0) | (dy_ff != '0) | (dz_ff != '0);
   end

   // stage c3: squares
   logic [2*W_M-1:0] qx_ff, qy_ff, qz_ff, qx_in, qy_in, qz_in;
   logic             big3_ff, nz3_ff;

   assign qx_in = mx_ff * mx_ff;
   assign qy_in = my_ff * my_ff;
   assign qz_in = mz_ff * mz_ff;

   // stage c4: sum and compare
   logic near_in;
   logic [W_SQ-1:0] sum;

   assign sum     = W_SQ'(qx_ff) + W_SQ'(qy_ff) + W_SQ'(qz_ff);
   assign near_in = nz3_ff & ~big3_ff & (sum <= THR_Q);

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      mz_ff   <= mz_in;
      big2_ff <= big2_in;
      nz2_ff  <= nz2_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      qz_ff   <= qz_in;
      big3_ff <= big2_ff;
      nz3_ff  <= nz2_ff;
      near    <= near_in;
   end

endmodule
`default_nettype wire

// ===== sv/orthographic_map_point_projector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// orthographic_map_point_projector
// Rotates map vertices into the view frame, projects them orthographically
// to screen pixels and tags each one with a pen action.
//
//   channel  ports                               direction  handshake
//   request  start, busy, req_*                  in         start & !busy
//   result   rsp_valid, rsp_*                    out        rsp_valid, 1 cycle
//   config   csr_valid, csr_ready, csr_index,    in         valid & ready
//            csr_wdata
//
// One item enters per cycle; each result comes out of the nine-stage multiply
// pipeline, with the chord check running in parallel.
// busy is high only during reset. Reset clears valid bits and loads the
// configuration defaults. The receiver cannot stall, so the pipeline never
// holds; csr_ready is always high.
// ----------------------------------------------------------------------------
module orthographic_map_point_projector #(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  wire                clock,
   input  wire                reset,
   // request
   input  wire                start,
   output logic               busy,
   input  wire logic signed [15:0] req_cos_lat,
   input  wire logic signed [15:0] req_sin_lat,
   input  wire logic signed [15:0] req_cos_lng,
   input  wire logic signed [15:0] req_sin_lng,
   input  wire logic [7:0]    req_color_tag,
   // result
   output logic               rsp_valid,
   output logic signed [15:0] rsp_screen_x,
   output logic signed [15:0] rsp_screen_y,
   output logic [1:0]         rsp_pen_action,
   output logic [7:0]         rsp_pen_color,
   // configuration
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [15:0]   csr_wdata
);

   localparam int F      = TRIG_FRAC_BITS;
   localparam int W_M    = 49;
   localparam int W_XC   = W_M - F;
   localparam int W_ZS   = W_XC + 16;
   localparam int W_ZT   = W_ZS - F;
   localparam int W_YR   = ((W_ZT > 32) ? W_ZT : 32) + 1;
   localparam int W_XP   = W_XC + 17;
   localparam int W_XPX  = (W_XP > 2 * F + 2) ? W_XP : 2 * F + 2;
   localparam int W_PX   = W_XPX - 2 * F;
   localparam int W_YP   = W_YR + 17;
   localparam int W_YPX  = (W_YP > 2 * F + 2) ? W_YP : 2 * F + 2;
   localparam int W_PY   = W_YPX - 2 * F;
   localparam int W_PM   = (W_PX > W_PY) ? W_PX : W_PY;
   localparam int W_SUM  = ((W_PM > 16) ? W_PM : 16) + 2;
   localparam logic signed [W_SUM-1:0] SAT_HI = W_SUM'(omp_pkg::SCREEN_MAX);
   localparam logic signed [W_SUM-1:0] SAT_LO = W_SUM'(omp_pkg::SCREEN_MIN);
   localparam int DEPTH  = 9;

   logic accept;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // configuration registers
   logic signed [15:0] sin_center_lat_ff, cos_center_lat_ff;
   logic signed [15:0] sin_center_lng_ff, cos_center_lng_ff;
   logic [15:0]        pixel_scale_ff;
   logic [13:0]        half_width_ff, half_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_center_lat_ff <= 16'sd0;
         cos_center_lat_ff <= 16'sd16384;
         sin_center_lng_ff <= 16'sd0;
         cos_center_lng_ff <= 16'sd16384;
         pixel_scale_ff    <= 16'd256;
         half_width_ff     <= 14'd320;
         half_height_ff    <= 14'd240;
      end else if (csr_valid && csr_ready) begin
         case (omp_pkg::csr_index_type'(csr_index))
            omp_pkg::CSR_SIN_CENTER_LAT: sin_center_lat_ff <= $signed(csr_wdata);
            omp_pkg::CSR_COS_CENTER_LAT: cos_center_lat_ff <= $signed(csr_wdata);
            omp_pkg::CSR_SIN_CENTER_LNG: sin_center_lng_ff <= $signed(csr_wdata);
            omp_pkg::CSR_COS_CENTER_LNG: cos_center_lng_ff <= $signed(csr_wdata);
            omp_pkg::CSR_PIXEL_SCALE:    pixel_scale_ff    <= csr_wdata;
            omp_pkg::CSR_HALF_WIDTH:     half_width_ff     <= csr_wdata[13:0];
            omp_pkg::CSR_HALF_HEIGHT:    half_height_ff    <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   logic signed [16:0] scale_s;
   assign scale_s = $signed({1'b0, pixel_scale_ff});

   // valid bits, one per stage
   logic [DEPTH-1:0] vld_ff, vld_in;
   assign vld_in = {vld_ff[DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: longitude rotation products
   logic signed [31:0] p_sc_ff, p_cs_ff, p_cc_ff, p_ss_ff;
   logic signed [31:0] p_sc_in, p_cs_in, p_cc_in, p_ss_in;
   logic signed [15:0] cl1_ff, sl1_ff;
   logic [7:0]         col1_ff;

   assign p_sc_in = req_sin_lng * cos_center_lng_ff;
   assign p_cs_in = req_cos_lng * sin_center_lng_ff;
   assign p_cc_in = req_cos_lng * cos_center_lng_ff;
   assign p_ss_in = req_sin_lng * sin_center_lng_ff;

   // stage 2: rotated longitude sine and cosine
   logic signed [32:0] s2_ff, c2_ff, s2_in, c2_in;
   logic signed [15:0] cl2_ff, sl2_ff;
   logic [7:0]         col2_ff;

   assign s2_in = 33'(p_sc_ff) - 33'(p_cs_ff);
   assign c2_in = 33'(p_cc_ff) + 33'(p_ss_ff);

   // stage 3: scale by cosine of latitude
   logic signed [W_M-1:0] ms3_ff, mc3_ff, ms3_in, mc3_in;
   logic signed [15:0]    sl3_ff;
   logic [7:0]            col3_ff;

   assign ms3_in = cl2_ff * s2_ff;
   assign mc3_in = cl2_ff * c2_ff;

   // stage 4: truncate to xc, zc; latitude product
   logic signed [W_XC-1:0] xc4_ff, zc4_ff, xc4_in, zc4_in;
   logic signed [31:0]     yl4_ff, yl4_in;
   logic signed [15:0]     sl4_ff;
   logic [7:0]             col4_ff;

   always_comb begin
      logic signed [W_M-1:0] xa, za;
      xa = ms3_ff + W_M'({F{ms3_ff[W_M-1]}});
      za = mc3_ff + W_M'({F{mc3_ff[W_M-1]}});
      xc4_in = $signed(xa[W_M-1:F]);
      zc4_in = $signed(za[W_M-1:F]);
   end
   assign yl4_in = sl3_ff * cos_center_lat_ff;

   // stage 5: tilt product and horizontal pixel product
   logic signed [W_ZS-1:0] zs5_ff, zs5_in;
   logic signed [W_XP-1:0] xp5_ff, xp5_in;
   logic signed [31:0]     yl5_ff;
   logic [7:0]             col5_ff;

   assign zs5_in = zc4_ff * sin_center_lat_ff;
   assign xp5_in = xc4_ff * scale_s;

   // stage 6: rotated y and horizontal pixel offset
   logic signed [W_YR-1:0] yr6_ff, yr6_in;
   logic signed [W_PX-1:0] px6_ff, px6_in;
   logic [7:0]             col6_ff;

   always_comb begin
      logic signed [W_ZS-1:0]  za;
      logic signed [W_ZT-1:0]  zt;
      logic signed [W_XPX-1:0] xe, xa;
      za = zs5_ff + W_ZS'({F{zs5_ff[W_ZS-1]}});
      zt = $signed(za[W_ZS-1:F]);
      yr6_in = W_YR'(yl5_ff) - W_YR'(zt);
      xe = W_XPX'(xp5_ff);
      xa = xe + W_XPX'({(2 * F){xe[W_XPX-1]}});
      px6_in = $signed(xa[W_XPX-1:2*F]);
   end

   // stage 7: vertical pixel product
   logic signed [W_YP-1:0] yp7_ff, yp7_in;
   logic signed [W_PX-1:0] px7_ff;
   logic [7:0]             col7_ff;

   assign yp7_in = yr6_ff * scale_s;

   // stage 8: vertical offset, x sum, center flag
   logic signed [W_PY-1:0]  py8_ff, py8_in;
   logic signed [W_SUM-1:0] sx8_ff, sx8_in;
   logic                    pxz8_ff, pxz8_in;
   logic [7:0]              col8_ff;

   always_comb begin
      logic signed [W_YPX-1:0] ye, ya;
      ye = W_YPX'(yp7_ff);
      ya = ye + W_YPX'({(2 * F){ye[W_YPX-1]}});
      py8_in  = $signed(ya[W_YPX-1:2*F]);
      sx8_in  = $signed(W_SUM'(half_width_ff)) + W_SUM'(px7_ff);
      pxz8_in = (px7_ff == '0);
   end

   // chord distance check, aligned with stage 8
   logic near8;

   omp_chord #(
      .F    (F),
      .W_XC (W_XC)
   ) u_chord (
      .clock          (clock),
      .xc             (xc4_ff),
      .zc             (zc4_ff),
      .sin_lat        (sl4_ff),
      .sin_center_lat (sin_center_lat_ff),
      .cos_center_lat (cos_center_lat_ff),
      .near           (near8)
   );

   // stage 9: y sum, saturation, pen action
   logic signed [15:0]      sx9_in, sy9_in;
   logic [1:0]              act9_in;

   always_comb begin
      logic signed [W_SUM-1:0] sy;
      omp_pkg::pen_action_type act;
      sy = $signed(W_SUM'(half_height_ff)) - W_SUM'(py8_ff);
      if (sx8_ff > SAT_HI) begin
         sx9_in = 16'(SAT_HI);
      end else if (sx8_ff < SAT_LO) begin
         sx9_in = 16'(SAT_LO);
      end else begin
         sx9_in = sx8_ff[15:0];
      end
      if (sy > SAT_HI) begin
         sy9_in = 16'(SAT_HI);
      end else if (sy < SAT_LO) begin
         sy9_in = 16'(SAT_LO);
      end else begin
         sy9_in = sy[15:0];
      end
      if (col8_ff != 8'd0) begin
         act = omp_pkg::PEN_COLOR;
      end else if (near8 && !(pxz8_ff && (py8_ff == '0))) begin
         act = omp_pkg::PEN_LINE;
      end else begin
         act = omp_pkg::PEN_MOVE;
      end
      act9_in = act;
   end

   assign rsp_valid = vld_ff[DEPTH-1];

   // payload registers
   always_ff @(posedge clock) begin
      p_sc_ff        <= p_sc_in;
      p_cs_ff        <= p_cs_in;
      p_cc_ff        <= p_cc_in;
      p_ss_ff        <= p_ss_in;
      cl1_ff         <= req_cos_lat;
      sl1_ff         <= req_sin_lat;
      col1_ff        <= req_color_tag;
      s2_ff          <= s2_in;
      c2_ff          <= c2_in;
      cl2_ff         <= cl1_ff;
      sl2_ff         <= sl1_ff;
      col2_ff        <= col1_ff;
      ms3_ff         <= ms3_in;
      mc3_ff         <= mc3_in;
      sl3_ff         <= sl2_ff;
      col3_ff        <= col2_ff;
      xc4_ff         <= xc4_in;
      zc4_ff         <= zc4_in;
      yl4_ff         <= yl4_in;
      sl4_ff         <= sl3_ff;
      col4_ff        <= col3_ff;
      zs5_ff         <= zs5_in;
      xp5_ff         <= xp5_in;
      yl5_ff         <= yl4_ff;
      col5_ff        <= col4_ff;
      yr6_ff         <= yr6_in;
      px6_ff         <= px6_in;
      col6_ff        <= col5_ff;
      yp7_ff         <= yp7_in;
      px7_ff         <= px6_ff;
      col7_ff        <= col6_ff;
      py8_ff         <= py8_in;
      sx8_ff         <= sx8_in;
      pxz8_ff        <= pxz8_in;
      col8_ff        <= col7_ff;
      rsp_screen_x   <= sx9_in;
      rsp_screen_y   <= sy9_in;
      rsp_pen_action <= act9_in;
      rsp_pen_color  <= col8_ff;
   end

   // checks
   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, DEPTH))
      else $error("result without matching accepted item");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##9 rsp_valid)
      else $error("accepted item produced no result");

   a_line_needs_no_color: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pen_action == omp_pkg::PEN_LINE) |-> rsp_pen_color == 8'd0)
      else $error("line-to with a nonzero color");

   a_flush_on_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

endmodule
`default_nettype wire
